FILE: src/pdsd_pkg.sv
`default_nettype none

package pdsd_pkg;

    // default for the data symbol limit of one packet
    localparam int MAX_DATA_SYMBOLS_DEFAULT = 64;

    // input operation codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // result kind codes
    localparam logic [1:0] KIND_ORDERED_SET = 2'd0;
    localparam logic [1:0] KIND_DATA        = 2'd1;
    localparam logic [1:0] KIND_END         = 2'd2;

    // line codes
    localparam logic [4:0] CODE_SYNC1 = 5'h18;
    localparam logic [4:0] CODE_SYNC2 = 5'h11;
    localparam logic [4:0] CODE_SYNC3 = 5'h06;
    localparam logic [4:0] CODE_RST1  = 5'h07;
    localparam logic [4:0] CODE_RST2  = 5'h19;
    localparam logic [4:0] CODE_EOP   = 5'h0d;

    localparam logic [2:0]  SOP_NONE  = 3'd7;
    localparam logic [31:0] CRC_INIT  = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY  = 32'hedb8_8320;

    // 5b4b decode, k-codes map to their own code
    localparam logic [4:0] DEC_TABLE [0:31] = '{
        5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h07,
        5'h00, 5'h01, 5'h04, 5'h05, 5'h00, 5'h0d, 5'h06, 5'h07,
        5'h00, 5'h11, 5'h08, 5'h09, 5'h02, 5'h03, 5'h0a, 5'h0b,
        5'h18, 5'h19, 5'h0c, 5'h0d, 5'h0e, 5'h0f, 5'h00, 5'h00
    };

    // start-of-packet orders
    localparam logic [4:0] SOP_ORDERS [0:6][0:3] = '{
        '{CODE_SYNC1, CODE_SYNC1, CODE_SYNC1, CODE_SYNC2},
        '{CODE_SYNC1, CODE_SYNC1, CODE_SYNC3, CODE_SYNC3},
        '{CODE_SYNC1, CODE_SYNC3, CODE_SYNC1, CODE_SYNC3},
        '{CODE_SYNC1, CODE_RST2,  CODE_RST2,  CODE_SYNC3},
        '{CODE_SYNC1, CODE_RST2,  CODE_SYNC3, CODE_SYNC2},
        '{CODE_RST1,  CODE_RST1,  CODE_RST1,  CODE_RST2},
        '{CODE_RST1,  CODE_SYNC1, CODE_RST1,  CODE_SYNC3}
    };

    // framing state carried from one symbol to the next
    typedef struct packed {
        logic [3:0][4:0] store;
        logic [31:0]     crc;
        logic            ended;
    } pdsd_state_t;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  sop_class;
        logic [4:0]  decoded;
        logic [4:0]  raw;
        logic [31:0] crc;
        logic        hard_reset;
        logic        last;
    } pdsd_result_t;

    // reflected crc-32 over one nibble
    function automatic logic [31:0] crc_nibble(input logic [31:0] crc, input logic [3:0] v);
        logic [31:0] x;
        x = crc ^ {28'd0, v};
        for (int i = 0; i < 4; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    // first order with at least 3 of 4 entries in agreement, else none
    function automatic logic [2:0] classify(input logic [3:0][4:0] store);
        logic [2:0] cls;
        logic [2:0] hits;
        cls = SOP_NONE;
        for (int j = 6; j >= 0; j--) begin
            hits = 3'd0;
            for (int i = 0; i < 4; i++) begin
                hits = hits + {2'd0, store[i] == SOP_ORDERS[j][i]};
            end
            if (hits >= 3'd3) begin
                cls = 3'(j);
            end
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

FILE: src/pdsd_symbol_step.sv
`default_nettype none

module pdsd_symbol_step #(
    parameter int MAX_DATA_SYMBOLS = pdsd_pkg::MAX_DATA_SYMBOLS_DEFAULT,
    parameter int CNT_W            = $clog2(MAX_DATA_SYMBOLS + 5)
) (
    input  wire logic [4:0]         sym,
    input  wire logic               hard_reset,
    input  wire logic [CNT_W-1:0]   cnt,
    input  wire pdsd_pkg::pdsd_state_t st,
    output logic [CNT_W-1:0]        cnt_next,
    output pdsd_pkg::pdsd_state_t   st_next,
    output logic                    emit,
    output pdsd_pkg::pdsd_result_t  result
);

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(4 + MAX_DATA_SYMBOLS);
    localparam logic [CNT_W-1:0] HDR_LEN = CNT_W'(4);
    localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(3);

    logic [4:0] dec;

    assign dec = pdsd_pkg::DEC_TABLE[sym];

    // one symbol through the packet state
    always_comb begin
        cnt_next          = cnt;
        st_next           = st;
        emit              = 1'b0;
        result.kind       = pdsd_pkg::KIND_DATA;
        result.sop_class  = 3'd0;
        result.decoded    = dec;
        result.raw        = sym;
        result.crc        = st.crc;
        result.hard_reset = hard_reset;
        result.last       = 1'b0;
        priority if (st.ended) begin
            emit = 1'b0;
        end else if (sym == pdsd_pkg::CODE_EOP || cnt >= LIMIT) begin
            st_next.ended = 1'b1;
            emit          = 1'b1;
            result.kind   = pdsd_pkg::KIND_END;
        end else if (cnt < HDR_LEN) begin
            st_next.store[cnt[1:0]] = sym;
            cnt_next                = cnt + 1'b1;
            if (cnt == HDR_LAST) begin
                st_next.crc      = pdsd_pkg::CRC_INIT;
                emit             = 1'b1;
                result.kind      = pdsd_pkg::KIND_ORDERED_SET;
                result.sop_class = pdsd_pkg::classify(st_next.store);
                result.crc       = pdsd_pkg::CRC_INIT;
            end
        end else begin
            st_next.crc = pdsd_pkg::crc_nibble(st.crc, dec[3:0]);
            cnt_next    = cnt + 1'b1;
            emit        = 1'b1;
            result.crc  = st_next.crc;
        end
    end

endmodule

`default_nettype wire

FILE: src/pd_symbol_deframer_unit.sv
`default_nettype none

// Power delivery 4b5b receiver front end. Each s_ transfer carries one line
// byte (earliest bit in bit 0) or, with s_tuser high, a restart that drops
// framing and hunts for a Sync-1 or RST-1 code again. A byte gives zero, one
// or two results on the m_ side; m_tlast marks the final result of a byte.
// A byte is taken in every cycle while it gives at most one result and
// m_tready is high; after a byte that gives two results, the next byte
// waits until the second leaves the single result port, a limit set by
// the two-entry result buffer in front of m_. Results are registered and
// appear in the cycle after the byte is taken.
module pd_symbol_deframer_unit #(
    parameter int MAX_DATA_SYMBOLS = pdsd_pkg::MAX_DATA_SYMBOLS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] line_byte
    input  wire logic        s_tuser,   // [0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [2:0] sop_class, [7:3] decoded_value,
                                        // [12:8] raw_symbol, [44:13] crc_value,
                                        // [45] hard_reset_start, [47:46] zero
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast    // last
);

    localparam int CNT_W = $clog2(MAX_DATA_SYMBOLS + 5);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(4 + MAX_DATA_SYMBOLS);

    // framing registers
    logic [7:0]       prev_reg;
    logic [3:0]       offset_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [3:0][4:0]  store_reg;
    logic [31:0]      crc_reg;
    logic             ended_reg;
    logic             rf_reg;

    // result buffer
    logic [1:0]             count_reg;
    logic [1:0]             count_next;
    pdsd_pkg::pdsd_result_t q0_reg;
    pdsd_pkg::pdsd_result_t q1_reg;

    logic [15:0] window;
    logic        hunting;
    logic        found;
    logic [3:0]  hunt_s;
    logic        hunt_rf;
    logic [3:0]  s0;
    logic [2:0]  s1_low;
    logic [3:0]  s1;
    logic [2:0]  s2_low;
    logic [3:0]  s2;
    logic        two;
    logic [4:0]  sym1;
    logic [4:0]  sym2;
    logic        rf_cur;
    logic        s_xfer;
    logic        m_xfer;
    logic        framed;
    logic        push;

    pdsd_pkg::pdsd_state_t  st_cur;
    pdsd_pkg::pdsd_state_t  st_a;
    pdsd_pkg::pdsd_state_t  st_b;
    pdsd_pkg::pdsd_state_t  st_fin;
    logic [CNT_W-1:0]       cnt_a;
    logic [CNT_W-1:0]       cnt_b;
    logic [CNT_W-1:0]       cnt_fin;
    logic                   emit_a;
    logic                   emit_b;
    logic                   emit_b_ok;
    pdsd_pkg::pdsd_result_t res_a;
    pdsd_pkg::pdsd_result_t res_b;
    pdsd_pkg::pdsd_result_t new0;
    pdsd_pkg::pdsd_result_t new1;

    assign window  = {s_tdata, prev_reg};
    assign hunting = (cnt_reg == '0);
    assign s_xfer  = s_tvalid && s_tready;
    assign m_xfer  = m_tvalid && m_tready;

    // sync search, highest offset first, sync-1 ahead of rst-1
    always_comb begin
        logic [4:0] t;
        found   = 1'b0;
        hunt_s  = 4'd8;
        hunt_rf = 1'b0;
        for (int k = 1; k <= 8; k++) begin
            t = window[k +: 5];
            if (t == pdsd_pkg::CODE_SYNC1) begin
                found   = 1'b1;
                hunt_s  = 4'(k);
                hunt_rf = 1'b0;
            end else if (t == pdsd_pkg::CODE_RST1) begin
                found   = 1'b1;
                hunt_s  = 4'(k);
                hunt_rf = 1'b1;
            end
        end
    end

    // symbol cut positions
    always_comb begin
        if (hunting) begin
            s0 = hunt_s;
        end else if (offset_reg == 4'd0 || offset_reg > 4'd8) begin
            s0 = 4'd8;
        end else begin
            s0 = offset_reg;
        end
        s1_low = s0[2:0] + 3'd5;
        s1     = (s1_low == 3'd0) ? 4'd8 : {1'b0, s1_low};
        s2_low = s1[2:0] + 3'd5;
        s2     = (s2_low == 3'd0) ? 4'd8 : {1'b0, s2_low};
        two    = (s1 < 4'd4);
    end

    assign sym1   = 5'(window >> s0);
    assign sym2   = 5'(s_tdata >> s1[1:0]);
    assign rf_cur = hunting ? hunt_rf : rf_reg;
    assign framed = (s_tuser == pdsd_pkg::OP_BYTE) && (!hunting || found);

    assign st_cur.store = store_reg;
    assign st_cur.crc   = crc_reg;
    assign st_cur.ended = ended_reg;

    pdsd_symbol_step #(
        .MAX_DATA_SYMBOLS (MAX_DATA_SYMBOLS),
        .CNT_W            (CNT_W)
    ) u_step_a (
        .sym        (sym1),
        .hard_reset (rf_cur),
        .cnt        (cnt_reg),
        .st         (st_cur),
        .cnt_next   (cnt_a),
        .st_next    (st_a),
        .emit       (emit_a),
        .result     (res_a)
    );

    pdsd_symbol_step #(
        .MAX_DATA_SYMBOLS (MAX_DATA_SYMBOLS),
        .CNT_W            (CNT_W)
    ) u_step_b (
        .sym        (sym2),
        .hard_reset (rf_cur),
        .cnt        (cnt_a),
        .st         (st_a),
        .cnt_next   (cnt_b),
        .st_next    (st_b),
        .emit       (emit_b),
        .result     (res_b)
    );

    assign emit_b_ok = two && emit_b;
    assign st_fin    = two ? st_b : st_a;
    assign cnt_fin   = two ? cnt_b : cnt_a;
    assign push      = s_xfer && framed && (emit_a || emit_b_ok);

    // order the new results and mark the final one
    always_comb begin
        new0 = emit_a ? res_a : res_b;
        new1 = res_b;
        new0.last = !(emit_a && emit_b_ok);
        new1.last = 1'b1;
    end

    // take a byte while the buffer is empty or its single entry leaves now
    assign s_tready = (count_reg == 2'd0) || (count_reg == 2'd1 && m_tready);

    always_comb begin
        if (push) begin
            count_next = (emit_a && emit_b_ok) ? 2'd2 : 2'd1;
        end else if (s_xfer || m_xfer) begin
            count_next = (count_reg == 2'd0) ? 2'd0 : count_reg - 2'd1;
        end else begin
            count_next = count_reg;
        end
    end

    // framing control state and result buffer count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= 8'd0;
            offset_reg <= 4'd0;
            cnt_reg    <= '0;
            crc_reg    <= pdsd_pkg::CRC_INIT;
            ended_reg  <= 1'b0;
            rf_reg     <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (s_xfer) begin
                if (s_tuser == pdsd_pkg::OP_RESTART) begin
                    offset_reg <= 4'd0;
                    cnt_reg    <= '0;
                    crc_reg    <= pdsd_pkg::CRC_INIT;
                    ended_reg  <= 1'b0;
                    rf_reg     <= 1'b0;
                end else begin
                    prev_reg <= s_tdata;
                    if (framed) begin
                        offset_reg <= two ? s2 : s1;
                        cnt_reg    <= cnt_fin;
                        crc_reg    <= st_fin.crc;
                        ended_reg  <= st_fin.ended;
                        rf_reg     <= rf_cur;
                    end
                end
            end
        end
    end

    // ordered set entries and result payload
    always_ff @(posedge aclk) begin
        if (s_xfer && framed) begin
            store_reg <= st_fin.store;
        end
        if (push) begin
            q0_reg <= new0;
            q1_reg <= new1;
        end else if (m_xfer) begin
            q0_reg <= q1_reg;
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {2'b00, q0_reg.hard_reset, q0_reg.crc, q0_reg.raw,
                       q0_reg.decoded, q0_reg.sop_class};
    assign m_tuser  = q0_reg.kind;
    assign m_tlast  = q0_reg.last;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_restart_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == pdsd_pkg::OP_RESTART |=> count_reg == 2'd0)
        else $error("restart left results pending");

    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("second result of a byte missing");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LIMIT)
        else $error("symbol count beyond limit");

    a_ended_framed: assert property (@(posedge aclk) disable iff (!aresetn)
        ended_reg |-> cnt_reg != '0)
        else $error("packet end latched while hunting");
`endif

endmodule

`default_nettype wire
